/* rtl/rtufic_pkg.sv */
package rtufic_pkg;

    localparam int MAX_FRAME = 256;
    localparam int CNT_W     = $clog2(MAX_FRAME + 1);
    localparam int MIN_FRAME = 3;

    localparam logic [15:0] CRC_PRESET = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'hA001;

    localparam logic [7:0] BROADCAST_ADDR = 8'h00;
    localparam logic [7:0] HIGHEST_UNIT   = 8'd247;

    localparam logic [2:0] V_VALID   = 3'd0;
    localparam logic [2:0] V_IGNORED = 3'd1;
    localparam logic [2:0] V_CRC_ERR = 3'd2;
    localparam logic [2:0] V_SHORT   = 3'd3;
    localparam logic [2:0] V_LONG    = 3'd4;

    localparam int          CFG_ADDR_W   = 3;
    localparam logic        CFG_IDX_OWN  = 1'b0;

    typedef struct packed {
        logic       step;
        logic       feed;
        logic       clear;
        logic [7:0] data;
    } t_crc_ctrl;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

/* rtl/rtufic_crc_unit.sv */
module rtufic_crc_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  rtufic_pkg::t_crc_ctrl i_ctrl,
    output logic [15:0]           o_crc_next,
    output logic [15:0]           o_crc_reg,
    output logic [7:0]            o_prev_byte
);

    logic [15:0] r_crc;
    logic [15:0] n_crc;
    logic [7:0]  r_d0;
    logic [7:0]  r_d1;

    always_comb begin
        if (i_ctrl.feed) begin
            n_crc = rtufic_pkg::crc_feed(r_crc, r_d1);
        end else begin
            n_crc = r_crc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= rtufic_pkg::CRC_PRESET;
            r_d0  <= 8'h00;
            r_d1  <= 8'h00;
        end else if (i_ctrl.step) begin
            if (i_ctrl.clear) begin
                r_crc <= rtufic_pkg::CRC_PRESET;
                r_d0  <= 8'h00;
                r_d1  <= 8'h00;
            end else begin
                r_crc <= n_crc;
                r_d1  <= r_d0;
                r_d0  <= i_ctrl.data;
            end
        end
    end

    assign o_crc_next  = n_crc;
    assign o_crc_reg   = r_crc;
    assign o_prev_byte = r_d0;

endmodule

/* rtl/rtu_frame_integrity_check_core.sv */
// A frame's verdict passes through the input register and then the result register
// before it reaches the outputs.
// Throughput: one byte per cycle unless a held verdict stalls the input; the byte-wide
// CRC update sits between the input register and the result register, so nothing iterates.
// Reset is synchronous and active low: the unit address returns to 0, the CRC to
// its preset and all frame tracking to its empty state.
module rtu_frame_integrity_check_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [7:0]                        i_data_byte,
    input  logic                              i_last_byte,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [2:0]                        o_verdict,
    output logic [8:0]                        o_frame_length,
    output logic [15:0]                       o_crc_computed,
    output logic [15:0]                       o_crc_received,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rtufic_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    logic [7:0]                  r_own_addr;
    logic                        cfg_write;

    logic                        r_in_valid;
    logic [7:0]                  r_in_byte;
    logic                        r_in_last;
    logic                        advance;
    logic                        proc_byte;

    logic [rtufic_pkg::CNT_W-1:0] r_count;
    logic [rtufic_pkg::CNT_W-1:0] n_count;
    logic [7:0]                   r_addr;
    logic [7:0]                   n_addr;
    logic                         r_ovl;
    logic                         n_ovl;
    logic                         cnt_full;

    rtufic_pkg::t_crc_ctrl       crc_ctrl;
    logic [15:0]                 crc_next;
    logic [15:0]                 crc_reg;
    logic [7:0]                  prev_byte;

    logic [15:0]                 crc_out;
    logic [15:0]                 crc_rx;
    logic [2:0]                  verdict;

    logic                        r_out_valid;
    logic [2:0]                  r_verdict;
    logic [8:0]                  r_len;
    logic [15:0]                 r_crc_out;
    logic [15:0]                 r_crc_rx;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[2] == rtufic_pkg::CFG_IDX_OWN);
    assign prdata    = {24'h000000, r_own_addr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_addr <= 8'h00;
        end else if (cfg_write && (pwdata[7:0] <= rtufic_pkg::HIGHEST_UNIT)) begin
            r_own_addr <= pwdata[7:0];
        end
    end

    assign advance    = !(r_out_valid && i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign proc_byte  = r_in_valid && advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (advance || !r_in_valid) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((advance || !r_in_valid) && i_in_valid) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_byte;
        end
    end

    assign cnt_full = (r_count == rtufic_pkg::CNT_W'(rtufic_pkg::MAX_FRAME));
    assign n_count  = cnt_full ? r_count : r_count + rtufic_pkg::CNT_W'(1);
    assign n_ovl    = r_ovl || cnt_full;
    assign n_addr   = (r_count == '0) ? r_in_byte : r_addr;

    assign crc_ctrl.step  = proc_byte;
    assign crc_ctrl.feed  = (r_count >= rtufic_pkg::CNT_W'(2));
    assign crc_ctrl.clear = r_in_last;
    assign crc_ctrl.data  = r_in_byte;

    rtufic_crc_unit u_crc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (crc_ctrl),
        .o_crc_next  (crc_next),
        .o_crc_reg   (crc_reg),
        .o_prev_byte (prev_byte)
    );

    assign crc_out = {crc_next[7:0], crc_next[15:8]};
    assign crc_rx  = {prev_byte, r_in_byte};

    always_comb begin
        if (n_ovl) begin
            verdict = rtufic_pkg::V_LONG;
        end else if (n_count < rtufic_pkg::CNT_W'(rtufic_pkg::MIN_FRAME)) begin
            verdict = rtufic_pkg::V_SHORT;
        end else if ((n_addr != r_own_addr) && (n_addr != rtufic_pkg::BROADCAST_ADDR)) begin
            verdict = rtufic_pkg::V_IGNORED;
        end else if (crc_out == crc_rx) begin
            verdict = rtufic_pkg::V_VALID;
        end else begin
            verdict = rtufic_pkg::V_CRC_ERR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_addr  <= 8'h00;
            r_ovl   <= 1'b0;
        end else if (proc_byte) begin
            if (r_in_last) begin
                r_count <= '0;
                r_addr  <= 8'h00;
                r_ovl   <= 1'b0;
            end else begin
                r_count <= n_count;
                r_addr  <= n_addr;
                r_ovl   <= n_ovl;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= proc_byte && r_in_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc_byte && r_in_last) begin
            r_verdict <= verdict;
            r_len     <= 9'(n_count);
            if ((verdict == rtufic_pkg::V_VALID) || (verdict == rtufic_pkg::V_CRC_ERR)) begin
                r_crc_out <= crc_out;
                r_crc_rx  <= crc_rx;
            end else begin
                r_crc_out <= 16'h0000;
                r_crc_rx  <= 16'h0000;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_verdict      = r_verdict;
    assign o_frame_length = r_len;
    assign o_crc_computed = r_crc_out;
    assign o_crc_received = r_crc_rx;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= rtufic_pkg::CNT_W'(rtufic_pkg::MAX_FRAME))
        else $error("Byte count exceeds the maximum frame length.");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc_byte && r_in_last) |=>
            (r_count == '0) && !r_ovl && (crc_reg == rtufic_pkg::CRC_PRESET))
        else $error("Frame state was not cleared after the last byte.");

    a_crc_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_verdict != rtufic_pkg::V_VALID)
            && (o_verdict != rtufic_pkg::V_CRC_ERR))
            |-> (o_crc_computed == 16'h0000) && (o_crc_received == 16'h0000))
        else $error("CRC fields are not zero for a verdict without a CRC check.");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("Input stalled without a blocked transaction in the pipeline.");

endmodule
